// ===== hdl/ttx_pkg.sv =====
// ----------------------------------------------------------------------------
// Teletext packet decoder package
// Payload types, packet layout constants and Hamming 8/4 decode.
// ----------------------------------------------------------------------------
package ttx_pkg;

  localparam logic [5:0] MAG_BYTE          = 6'd3;
  localparam logic [5:0] ROW_BYTE          = 6'd4;
  localparam logic [5:0] UNITS_BYTE        = 6'd5;
  localparam logic [5:0] TENS_BYTE         = 6'd6;
  localparam logic [5:0] HEADER_TEXT_START = 6'd13;
  localparam logic [5:0] ROW_TEXT_START    = 6'd5;
  localparam logic [5:0] LAST_BYTE         = 6'd44;
  localparam logic [5:0] DONE_POS          = 6'd45;
  localparam logic [4:0] HEADER_ROW        = 5'd0;
  localparam logic [4:0] FIRST_SUB_ROW     = 5'd1;
  localparam logic [4:0] LAST_SUB_ROW      = 5'd4;
  localparam logic [4:0] LAST_TEXT_ROW     = 5'd24;
  localparam logic [3:0] MAG_RESET         = 4'd8;
  localparam logic [9:0] SUBTITLE_RESET    = 10'd888;
  localparam logic [5:0] ROW_COLUMNS       = 6'd40;
  localparam logic [5:0] HEADER_COLUMNS    = 6'd32;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       packet_start;
  } item_t;

  typedef struct packed {
    logic [9:0]  page_num;
    logic [4:0]  row;
    logic [5:0]  column;
    logic [6:0]  character;
    logic        parity_error;
    logic        subtitle_char;
    logic [15:0] packets_parsed;
  } result_t;

  typedef struct packed {
    logic    fail;
    logic [3:0] data;
  } ham_t;

  // Hamming 8/4: single errors corrected, double errors flagged
  function automatic ham_t hamming84(input logic [7:0] b);
    logic       fa;
    logic       fb;
    logic       fc;
    logic       all_par;
    logic [2:0] syn;
    logic [3:0] data;
    ham_t       res;
    fa      = ~(b[0] ^ b[1] ^ b[5] ^ b[7]);
    fb      = ~(b[1] ^ b[2] ^ b[3] ^ b[7]);
    fc      = ~(b[1] ^ b[3] ^ b[4] ^ b[5]);
    all_par = ^b;
    syn     = {fa, fb, fc};
    data    = {b[7], b[5], b[3], b[1]};
    res.fail = 1'b0;
    res.data = data;
    if (all_par) begin
      if (syn != 3'd0) begin
        res.fail = 1'b1;
      end
    end else begin
      case (syn)
        3'd7:    res.data = data ^ 4'b0001;
        3'd3:    res.data = data ^ 4'b0010;
        3'd5:    res.data = data ^ 4'b0100;
        3'd6:    res.data = data ^ 4'b1000;
        default: res.data = data;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== hdl/ttx_parse.sv =====
// ----------------------------------------------------------------------------
// Teletext packet parser
// Per-byte packet state, address and page decode, character result build.
// ----------------------------------------------------------------------------
module ttx_parse import ttx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  item_t      item,
  input  logic [9:0] subtitle_page,
  output logic       emit,
  output result_t    res
);

  logic [5:0]  byte_position;
  logic [3:0]  first_address_nibble;
  logic [3:0]  packet_magazine;
  logic [4:0]  packet_row;
  logic        packet_dropped;
  logic [3:0]  units_digit;
  logic [9:0]  active_page;
  logic        page_valid;
  logic [15:0] packet_counter;

  logic [5:0]  byte_position_next;
  logic [3:0]  first_address_nibble_next;
  logic [3:0]  packet_magazine_next;
  logic [4:0]  packet_row_next;
  logic        packet_dropped_next;
  logic [3:0]  units_digit_next;
  logic [9:0]  active_page_next;
  logic        page_valid_next;
  logic [15:0] packet_counter_next;

  logic [5:0]  pos;
  logic        dropped;
  ham_t        ham;
  logic        odd;
  logic [4:0]  row_dec;
  logic [5:0]  col;
  logic [9:0]  page_calc;

  assign ham       = hamming84(item.byte_value);
  assign odd       = ^item.byte_value;
  assign row_dec   = {ham.data, first_address_nibble[3]};
  assign page_calc = 10'(packet_magazine) * 10'd100 + 10'(ham.data) * 10'd10
                     + 10'(units_digit);

  always_comb begin
    pos     = item.packet_start ? 6'd0 : byte_position;
    dropped = item.packet_start ? 1'b0 : packet_dropped;

    byte_position_next        = pos;
    first_address_nibble_next = first_address_nibble;
    packet_magazine_next      = packet_magazine;
    packet_row_next           = packet_row;
    packet_dropped_next       = dropped;
    units_digit_next          = units_digit;
    active_page_next          = active_page;
    page_valid_next           = page_valid;
    packet_counter_next       = packet_counter;
    emit = 1'b0;
    col  = 6'd0;

    if (!dropped && pos < DONE_POS) begin
      byte_position_next = pos + 6'd1;
      if (pos == MAG_BYTE) begin
        if (ham.fail) begin
          packet_dropped_next = 1'b1;
        end else begin
          first_address_nibble_next = ham.data;
          packet_magazine_next = (ham.data[2:0] == 3'd0) ? MAG_RESET : {1'b0, ham.data[2:0]};
        end
      end else if (pos == ROW_BYTE) begin
        if (ham.fail) begin
          packet_dropped_next = 1'b1;
        end else begin
          packet_row_next = row_dec;
          if (row_dec != HEADER_ROW) begin
            packet_counter_next = packet_counter + 16'd1;
          end
        end
      end else if (pos >= UNITS_BYTE && packet_row == HEADER_ROW) begin
        if (pos == UNITS_BYTE) begin
          if (ham.fail) begin
            packet_dropped_next = 1'b1;
          end else begin
            units_digit_next = ham.data;
          end
        end else if (pos == TENS_BYTE) begin
          if (ham.fail) begin
            packet_dropped_next = 1'b1;
          end else begin
            active_page_next    = page_calc;
            page_valid_next     = 1'b1;
            packet_counter_next = packet_counter + 16'd1;
          end
        end else if (pos >= HEADER_TEXT_START && pos <= LAST_BYTE) begin
          emit = 1'b1;
          col  = pos - HEADER_TEXT_START;
        end
      end else if (pos >= ROW_TEXT_START && pos <= LAST_BYTE) begin
        if (packet_row <= LAST_TEXT_ROW && page_valid) begin
          emit = 1'b1;
          col  = pos - ROW_TEXT_START;
        end
      end
    end

    res.page_num       = active_page;
    res.row            = packet_row;
    res.column         = col;
    res.character      = odd ? item.byte_value[6:0] : 7'd0;
    res.parity_error   = ~odd;
    res.subtitle_char  = (packet_row >= FIRST_SUB_ROW) && (packet_row <= LAST_SUB_ROW)
                         && (active_page == subtitle_page);
    res.packets_parsed = packet_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= 6'd0;
      first_address_nibble <= 4'd0;
      packet_magazine      <= MAG_RESET;
      packet_row           <= HEADER_ROW;
      packet_dropped       <= 1'b1;
      units_digit          <= 4'd0;
      active_page          <= 10'd0;
      page_valid           <= 1'b0;
      packet_counter       <= 16'd0;
    end else if (fire) begin
      byte_position        <= byte_position_next;
      first_address_nibble <= first_address_nibble_next;
      packet_magazine      <= packet_magazine_next;
      packet_row           <= packet_row_next;
      packet_dropped       <= packet_dropped_next;
      units_digit          <= units_digit_next;
      active_page          <= active_page_next;
      page_valid           <= page_valid_next;
      packet_counter       <= packet_counter_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= DONE_POS)
    else $error("byte position past end of packet");

  a_page_needs_header: assert property (@(posedge clk) disable iff (rst)
    fire && emit && packet_row != HEADER_ROW |-> page_valid)
    else $error("row character before any header");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && !(pos == ROW_BYTE || pos == TENS_BYTE) |=> $stable(packet_counter))
    else $error("packet counter moved outside address or tens byte");
`endif

endmodule

// ===== hdl/teletext_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// Teletext packet decoder
// Decodes 45-byte level 1 packets into page-tagged display characters.
//
//   port group        dir  payload   handshake
//   item              in   item_t    item_valid / item_ready
//   result            out  result_t  result_valid / result_ready
//   subtitle_page     in   10 bits   subtitle_page_we, no wait
//
// One byte per cycle while the output is not stalled. A byte sits in the
// input register after its transfer and is decoded from there; its
// character then goes into the output register. While a character waits,
// one more byte is taken, then the input stalls until the character is
// taken. Synchronous reset; no bytes are used until the first start mark.
// ----------------------------------------------------------------------------
module teletext_packet_decoder import ttx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  input  logic       subtitle_page_we,
  input  logic [9:0] subtitle_page
);

  logic       in_valid;
  item_t      in_item;
  logic [9:0] sub_page;
  logic       advance;
  logic       emit;
  result_t    res;

  assign advance    = in_valid && (!result_valid || result_ready);
  assign item_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_page <= SUBTITLE_RESET;
    end else if (subtitle_page_we) begin
      sub_page <= subtitle_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      in_item <= item;
    end
  end

  ttx_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .item          (in_item),
    .subtitle_page (sub_page),
    .emit          (emit),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.row == HEADER_ROW ? result.column < HEADER_COLUMNS
                                               : result.column < ROW_COLUMNS))
    else $error("column out of range for row");

  a_subtitle_rows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.subtitle_char |->
      result.row >= FIRST_SUB_ROW && result.row <= LAST_SUB_ROW)
    else $error("subtitle flag outside rows 1 to 4");

  a_parity_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.parity_error |-> result.character == 7'd0)
    else $error("parity error with nonzero character");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("stalled input register lost its byte");
`endif

endmodule
